>>> rtl/fqks_pkg.sv
// ----------------------------------------------------------------------------
// fqks_pkg
// Shared types and constants of the record queue with key search.
// ----------------------------------------------------------------------------
package fqks_pkg;

  localparam int CodeW = 31;
  localparam int WordW = 32;
  localparam int OccW  = 5;
  localparam int CmdW  = 2;
  localparam int RecW  = CodeW + 2 * WordW;

  typedef enum logic [CmdW-1:0] {
    CMD_ENQ    = 2'd0,
    CMD_DEQ    = 2'd1,
    CMD_SEARCH = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_RDATA,
    RES_MATCH
  } res_src_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_DEQ,
    S_SCAN
  } state_e;

  typedef struct packed {
    logic     load;
    logic     push;
    logic     pop;
    logic     rd_head;
    logic     scan_start;
    logic     scan_step;
    logic     cmp_en;
    logic     finish;
    status_e  fin_status;
    res_src_e res_src;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [CmdW-1:0] cmd;
    logic            full;
    logic            empty;
    logic            scan_more;
    logic            match;
    logic            hit_seen;
  } dp_stat_t;

endpackage

>>> rtl/fqks_ctrl.sv
// ----------------------------------------------------------------------------
// fqks_ctrl
// Sequencer: decodes the latched command and steps the datapath through
// push, pop or the linear key scan.
// ----------------------------------------------------------------------------
module fqks_ctrl import fqks_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d           = state_q;
    cmd_o.load        = 1'b0;
    cmd_o.push        = 1'b0;
    cmd_o.pop         = 1'b0;
    cmd_o.rd_head     = 1'b0;
    cmd_o.scan_start  = 1'b0;
    cmd_o.scan_step   = 1'b0;
    cmd_o.cmp_en      = 1'b0;
    cmd_o.finish      = 1'b0;
    cmd_o.fin_status  = ST_OK;
    cmd_o.res_src     = RES_ZERO;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (stat_i.cmd == CMD_ENQ) begin
          cmd_o.finish = 1'b1;
          if (stat_i.full) begin
            cmd_o.fin_status = ST_FULL;
          end else begin
            cmd_o.push = 1'b1;
          end
          state_d = S_IDLE;
        end else if (stat_i.cmd == CMD_DEQ) begin
          if (stat_i.empty) begin
            cmd_o.finish     = 1'b1;
            cmd_o.fin_status = ST_EMPTY;
            state_d          = S_IDLE;
          end else begin
            cmd_o.rd_head = 1'b1;
            state_d       = S_DEQ;
          end
        end else if (stat_i.cmd == CMD_SEARCH) begin
          if (stat_i.empty) begin
            cmd_o.finish     = 1'b1;
            cmd_o.fin_status = ST_NOT_FOUND;
            state_d          = S_IDLE;
          end else begin
            cmd_o.scan_start = 1'b1;
            state_d          = S_SCAN;
          end
        end else begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_DEQ: begin
        cmd_o.pop     = 1'b1;
        cmd_o.finish  = 1'b1;
        cmd_o.res_src = RES_RDATA;
        state_d       = S_IDLE;
      end
      S_SCAN: begin
        cmd_o.cmp_en = 1'b1;
        if (stat_i.scan_more) begin
          cmd_o.scan_step = 1'b1;
        end else begin
          cmd_o.finish     = 1'b1;
          cmd_o.res_src    = RES_MATCH;
          cmd_o.fin_status = (stat_i.match || stat_i.hit_seen) ? ST_OK : ST_NOT_FOUND;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy = (state_q != S_IDLE);

endmodule

>>> rtl/fqks_dpath.sv
// ----------------------------------------------------------------------------
// fqks_dpath
// Record ring buffer, pointers, occupancy count, scan index and the
// registered result.
// ----------------------------------------------------------------------------
module fqks_dpath import fqks_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ctrl_cmd_t               cmd_i,
  output dp_stat_t                stat_o,
  input  logic [CmdW-1:0]         cmd_in_i,
  input  logic [CodeW-1:0]        key_code_i,
  input  logic signed [WordW-1:0] in_quantity_i,
  input  logic signed [WordW-1:0] in_price_i,
  output logic                    done_o,
  output logic [1:0]              status_o,
  output logic [CodeW-1:0]        out_code_o,
  output logic signed [WordW-1:0] out_quantity_o,
  output logic signed [WordW-1:0] out_price_o,
  output logic [OccW-1:0]         occupancy_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [RecW-1:0]  mem_q [DEPTH];
  logic [RecW-1:0]  rd_q;
  logic [RecW-1:0]  mrec_q;
  logic             hit_q;
  logic [CmdW-1:0]  cmd_q;
  logic [CodeW-1:0] key_q;
  logic [WordW-1:0] qty_q;
  logic [WordW-1:0] price_q;
  logic [AW-1:0]    head_q, head_d;
  logic [AW-1:0]    tail_q, tail_d;
  logic [AW-1:0]    scan_idx_q;
  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    issued_q;
  logic             done_q;
  logic [1:0]       status_q;
  logic [RecW-1:0]  res_q, res_d;
  logic [OccW-1:0]  occ_q;
  logic [CW+OccW-1:0] occ_ext;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic             match_now;

  function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] i);
    logic [AW-1:0] r;
    if (i == AW'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = i + AW'(1);
    end
    return r;
  endfunction

  // input latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q   <= cmd_in_i;
      key_q   <= key_code_i;
      qty_q   <= in_quantity_i;
      price_q <= in_price_i;
    end
  end

  // record memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem_q[tail_q] <= {key_q, qty_q, price_q};
    end
  end

  assign rd_en   = cmd_i.rd_head || cmd_i.scan_start || cmd_i.scan_step;
  assign rd_addr = cmd_i.scan_step ? scan_idx_q : head_q;

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  assign match_now = (rd_q[RecW-1 -: CodeW] == key_q);

  // pointers and count
  always_comb begin
    head_d = cmd_i.pop  ? next_idx(head_q) : head_q;
    tail_d = cmd_i.push ? next_idx(tail_q) : tail_q;
    unique case ({cmd_i.push, cmd_i.pop})
      2'b10:   count_d = count_q + CW'(1);
      2'b01:   count_d = count_q - CW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      tail_q     <= '0;
      count_q    <= '0;
      scan_idx_q <= '0;
      issued_q   <= '0;
      hit_q      <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      done_q  <= cmd_i.finish;
      if (cmd_i.scan_start) begin
        scan_idx_q <= next_idx(head_q);
        issued_q   <= CW'(1);
      end else if (cmd_i.scan_step) begin
        scan_idx_q <= next_idx(scan_idx_q);
        issued_q   <= issued_q + CW'(1);
      end
      if (cmd_i.scan_start) begin
        hit_q <= 1'b0;
      end else if (cmd_i.cmp_en && match_now) begin
        hit_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cmp_en && match_now) begin
      mrec_q <= rd_q;
    end
  end

  // result register
  assign occ_ext = {{OccW{1'b0}}, count_d};

  always_comb begin
    unique case (cmd_i.res_src)
      RES_RDATA: res_d = rd_q;
      RES_MATCH: res_d = match_now ? rd_q : (hit_q ? mrec_q : '0);
      default:   res_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      status_q <= cmd_i.fin_status;
      res_q    <= res_d;
      occ_q    <= occ_ext[OccW-1:0];
    end
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign out_code_o     = res_q[RecW-1 -: CodeW];
  assign out_quantity_o = $signed(res_q[2*WordW-1 -: WordW]);
  assign out_price_o    = $signed(res_q[WordW-1:0]);
  assign occupancy_o    = occ_q;

  assign stat_o.cmd       = cmd_q;
  assign stat_o.full      = (count_q == CW'(DEPTH));
  assign stat_o.empty     = (count_q == '0);
  assign stat_o.scan_more = (issued_q < count_q);
  assign stat_o.match     = match_now;
  assign stat_o.hit_seen  = hit_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("occupancy above depth");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> (count_q != CW'(DEPTH)))
    else $error("push into full ring");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> (count_q != '0))
    else $error("pop from empty ring");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (head_q == tail_q))
    else $error("pointers differ on empty ring");

endmodule

>>> rtl/fifo_queue_with_key_search.sv
// ----------------------------------------------------------------------------
// fifo_queue_with_key_search
// Bounded record FIFO (code, quantity, price) with a search by code.
// ----------------------------------------------------------------------------
// A transaction is taken at a clock edge with start high and busy low; cmd_i
// selects enqueue, dequeue or search, and key_code_i, in_quantity_i and
// in_price_i carry the record or the search key. Each transaction returns
// exactly one result: done_o is high for one cycle with status_o, the record
// fields and occupancy_o (records held afterwards). The receiver cannot stall.
// The search length is set by the single read port of the record memory, one
// entry per cycle, oldest to newest; the newest match is returned.
// done_o is high in the first cycle with busy low again, so the result and
// the next transaction are taken at the same edge.
// Reset empties the queue (pointers and count cleared); the record memory is
// not cleared and needs no clearing pass since only written entries are read.
// ----------------------------------------------------------------------------
module fifo_queue_with_key_search import fqks_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [CmdW-1:0]         cmd_i,
  input  logic [CodeW-1:0]        key_code_i,
  input  logic signed [WordW-1:0] in_quantity_i,
  input  logic signed [WordW-1:0] in_price_i,
  output logic                    done_o,
  output logic [1:0]              status_o,
  output logic [CodeW-1:0]        out_code_o,
  output logic signed [WordW-1:0] out_quantity_o,
  output logic signed [WordW-1:0] out_price_o,
  output logic [OccW-1:0]         occupancy_o
);

  ctrl_cmd_t ctrl_cmd;
  dp_stat_t  dp_stat;

  fqks_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (dp_stat),
    .cmd_o  (ctrl_cmd)
  );

  fqks_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (ctrl_cmd),
    .stat_o         (dp_stat),
    .cmd_in_i       (cmd_i),
    .key_code_i     (key_code_i),
    .in_quantity_i  (in_quantity_i),
    .in_price_i     (in_price_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .out_code_o     (out_code_o),
    .out_quantity_o (out_quantity_o),
    .out_price_o    (out_price_o),
    .occupancy_o    (occupancy_o)
  );

endmodule

>>> tb/sv/fifo_queue_with_key_search_tb.sv
// ----------------------------------------------------------------------------
// fifo_queue_with_key_search_tb
// Self-checking bench for the record FIFO with search by code.
// ----------------------------------------------------------------------------
// Transactions are driven on start/busy. A short directed table comes first:
// the empty and full queue, unused command, extreme field values, duplicate
// codes and a search past the wrap of the ring. After it come random
// transactions in fill, drain and mixed phases. Each accepted transaction is
// run through a local ring-buffer model. Each done_o strobe is compared field
// by field with the oldest expected result.
// ----------------------------------------------------------------------------
module fifo_queue_with_key_search_tb;
  import fqks_pkg::*;

  localparam int          FIFO_DEPTH   = 16;
  localparam int          RAND_ITEMS   = 600;
  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          MAX_REPORTS  = 10;
  localparam logic [1:0]  CMD_UNUSED   = 2'd3;

  typedef struct packed {
    status_e            st;
    logic [CodeW-1:0]   code;
    logic [WordW-1:0]   qty;
    logic [WordW-1:0]   price;
    logic [OccW-1:0]    occ;
  } queue_result_t;

  typedef struct packed {
    logic [CmdW-1:0]    op;
    logic [CodeW-1:0]   code;
    logic [WordW-1:0]   qty;
    logic [WordW-1:0]   price;
    logic [7:0]         reps;
    logic               chk;
    queue_result_t      res;
  } stim_row_t;

  localparam queue_result_t NO_RES = '{ST_OK, 31'd0, 32'd0, 32'd0, 5'd0};
  localparam int            N_ROWS = 18;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [CmdW-1:0]         cmd_i = CMD_ENQ;
  logic [CodeW-1:0]        key_code_i = '0;
  logic signed [WordW-1:0] in_quantity_i = '0;
  logic signed [WordW-1:0] in_price_i = '0;
  logic                    done_o;
  logic [1:0]              status_o;
  logic [CodeW-1:0]        out_code_o;
  logic signed [WordW-1:0] out_quantity_o;
  logic signed [WordW-1:0] out_price_o;
  logic [OccW-1:0]         occupancy_o;

  logic                    typed_valid = 1'b0;
  queue_result_t           typed_res = NO_RES;

  logic [CodeW-1:0]        code_mem [FIFO_DEPTH];
  logic [WordW-1:0]        qty_mem [FIFO_DEPTH];
  logic [WordW-1:0]        price_mem [FIFO_DEPTH];
  int                      head_idx = 0;
  int                      tail_idx = 0;
  int                      rec_count = 0;

  queue_result_t           pending_results [$];
  queue_result_t           want_res;
  queue_result_t           pred_res;
  logic [CodeW-1:0]        recent_codes [$];
  stim_row_t               dir_rows [N_ROWS];
  int                      mismatch_count = 0;
  int                      cycle_count = 0;

  fifo_queue_with_key_search #(
    .DEPTH(FIFO_DEPTH)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .cmd_i         (cmd_i),
    .key_code_i    (key_code_i),
    .in_quantity_i (in_quantity_i),
    .in_price_i    (in_price_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .out_code_o    (out_code_o),
    .out_quantity_o(out_quantity_o),
    .out_price_o   (out_price_o),
    .occupancy_o   (occupancy_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic queue_result_t apply_queue_op(logic [CmdW-1:0] op,
                                                   logic [CodeW-1:0] code,
                                                   logic [WordW-1:0] qty,
                                                   logic [WordW-1:0] price);
    queue_result_t r;
    int idx;
    r = NO_RES;
    case (op)
      CMD_ENQ: begin
        if (rec_count >= FIFO_DEPTH) begin
          r.st = ST_FULL;
        end else begin
          code_mem[tail_idx]  = code;
          qty_mem[tail_idx]   = qty;
          price_mem[tail_idx] = price;
          tail_idx  = (tail_idx + 1) % FIFO_DEPTH;
          rec_count = rec_count + 1;
        end
      end
      CMD_DEQ: begin
        if (rec_count == 0) begin
          r.st = ST_EMPTY;
        end else begin
          r.code    = code_mem[head_idx];
          r.qty     = qty_mem[head_idx];
          r.price   = price_mem[head_idx];
          head_idx  = (head_idx + 1) % FIFO_DEPTH;
          rec_count = rec_count - 1;
        end
      end
      CMD_SEARCH: begin
        r.st = ST_NOT_FOUND;
        idx  = head_idx;
        for (int n = 0; n < rec_count; n++) begin
          if (code_mem[idx] == code) begin
            r.st    = ST_OK;
            r.code  = code_mem[idx];
            r.qty   = qty_mem[idx];
            r.price = price_mem[idx];
          end
          idx = (idx + 1) % FIFO_DEPTH;
        end
      end
      default: ;
    endcase
    r.occ = rec_count[OccW-1:0];
    return r;
  endfunction

  // check results, then record the transaction taken at this edge
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else if (rst_ni) begin
      if (done_o) begin
        if (pending_results.size() == 0) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected result: status %0d code %h qty %h price %h occ %0d",
                     status_o, out_code_o, out_quantity_o, out_price_o, occupancy_o);
        end else begin
          want_res = pending_results.pop_front();
          if (status_o !== want_res.st || out_code_o !== want_res.code ||
              out_quantity_o !== want_res.qty || out_price_o !== want_res.price ||
              occupancy_o !== want_res.occ) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= MAX_REPORTS) begin
              $display("mismatch exp: status %0d code %h qty %h price %h occ %0d",
                       want_res.st, want_res.code, want_res.qty, want_res.price,
                       want_res.occ);
              $display("         got: status %0d code %h qty %h price %h occ %0d",
                       status_o, out_code_o, out_quantity_o, out_price_o, occupancy_o);
            end
          end
        end
      end
      if (start && !busy) begin
        pred_res = apply_queue_op(cmd_i, key_code_i, in_quantity_i, in_price_i);
        pending_results.push_back(typed_valid ? typed_res : pred_res);
      end
    end
  end

  task automatic send_transaction(input logic [CmdW-1:0] op,
                                  input logic [CodeW-1:0] code,
                                  input logic [WordW-1:0] qty,
                                  input logic [WordW-1:0] price,
                                  input logic chk,
                                  input queue_result_t res,
                                  input bit idle_en);
    while (idle_en && $urandom_range(0, 99) < 7) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start         <= 1'b1;
    cmd_i         <= op;
    key_code_i    <= code;
    in_quantity_i <= qty;
    in_price_i    <= price;
    typed_valid   <= chk;
    typed_res     <= res;
    do @(posedge clk_i); while (busy);
  endtask

  initial begin
    int pick;
    int enq_th;
    int deq_th;
    logic [CmdW-1:0]  op;
    logic [CodeW-1:0] code;
    bit idle_en;

    dir_rows = '{
      '{CMD_DEQ,    31'd0,          32'd0,          32'd0,          8'd1,  1'b1,
        '{ST_EMPTY, 31'd0, 32'd0, 32'd0, 5'd0}},
      '{CMD_SEARCH, 31'd0,          32'd0,          32'd0,          8'd1,  1'b1,
        '{ST_NOT_FOUND, 31'd0, 32'd0, 32'd0, 5'd0}},
      '{CMD_UNUSED, 31'h7FFFFFFF,   32'hFFFFFFFF,   32'hFFFFFFFF,   8'd1,  1'b1,
        '{ST_OK, 31'd0, 32'd0, 32'd0, 5'd0}},
      '{CMD_ENQ,    31'h7FFFFFFF,   32'h80000000,   32'h7FFFFFFF,   8'd1,  1'b1,
        '{ST_OK, 31'd0, 32'd0, 32'd0, 5'd1}},
      '{CMD_ENQ,    31'd0,          32'h7FFFFFFF,   32'h80000000,   8'd1,  1'b1,
        '{ST_OK, 31'd0, 32'd0, 32'd0, 5'd2}},
      '{CMD_ENQ,    31'h7FFFFFFF,   32'hFFFFFFFF,   32'h00000001,   8'd1,  1'b1,
        '{ST_OK, 31'd0, 32'd0, 32'd0, 5'd3}},
      '{CMD_SEARCH, 31'h7FFFFFFF,   32'd0,          32'd0,          8'd1,  1'b0, NO_RES},
      '{CMD_SEARCH, 31'd0,          32'd0,          32'd0,          8'd1,  1'b0, NO_RES},
      '{CMD_SEARCH, 31'h00012345,   32'd0,          32'd0,          8'd1,  1'b1,
        '{ST_NOT_FOUND, 31'd0, 32'd0, 32'd0, 5'd3}},
      '{CMD_DEQ,    31'd0,          32'd0,          32'd0,          8'd1,  1'b0, NO_RES},
      '{CMD_ENQ,    31'd100,        32'h55AA55AA,   32'hAA55AA55,   8'd14, 1'b0, NO_RES},
      '{CMD_ENQ,    31'd999,        32'd1,          32'd1,          8'd1,  1'b1,
        '{ST_FULL, 31'd0, 32'd0, 32'd0, 5'd16}},
      '{CMD_SEARCH, 31'd0,          32'd0,          32'd0,          8'd1,  1'b0, NO_RES},
      '{CMD_SEARCH, 31'd113,        32'd0,          32'd0,          8'd1,  1'b0, NO_RES},
      '{CMD_UNUSED, 31'd0,          32'd0,          32'd0,          8'd1,  1'b1,
        '{ST_OK, 31'd0, 32'd0, 32'd0, 5'd16}},
      '{CMD_DEQ,    31'd0,          32'd0,          32'd0,          8'd16, 1'b0, NO_RES},
      '{CMD_DEQ,    31'd0,          32'd0,          32'd0,          8'd1,  1'b1,
        '{ST_EMPTY, 31'd0, 32'd0, 32'd0, 5'd0}},
      '{CMD_SEARCH, 31'h7FFFFFFF,   32'd0,          32'd0,          8'd1,  1'b1,
        '{ST_NOT_FOUND, 31'd0, 32'd0, 32'd0, 5'd0}}
    };

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) begin
      for (int k = 0; k < dir_rows[r].reps; k++)
        send_transaction(dir_rows[r].op, dir_rows[r].code + CodeW'(k), dir_rows[r].qty,
                         dir_rows[r].price, dir_rows[r].chk, dir_rows[r].res, 1'b1);
    end

    // phases of 40: fill-heavy, drain-heavy, mixed
    for (int i = 0; i < RAND_ITEMS; i++) begin
      idle_en = !(i >= 200 && i < 350);
      case ((i / 40) % 3)
        0:       begin enq_th = 55; deq_th = 70; end
        1:       begin enq_th = 15; deq_th = 70; end
        default: begin enq_th = 35; deq_th = 65; end
      endcase
      pick = $urandom_range(0, 99);
      if (pick < enq_th)      op = CMD_ENQ;
      else if (pick < deq_th) op = CMD_DEQ;
      else if (pick < 95)     op = CMD_SEARCH;
      else                    op = CMD_UNUSED;
      pick = $urandom_range(0, 99);
      if (op == CMD_SEARCH && pick < 60 && recent_codes.size() > 0)
        code = recent_codes[$urandom_range(0, recent_codes.size() - 1)];
      else if (pick < 80)
        code = CodeW'($urandom_range(0, 15));
      else
        code = CodeW'($urandom);
      if (op == CMD_ENQ) begin
        recent_codes.push_back(code);
        if (recent_codes.size() > FIFO_DEPTH)
          void'(recent_codes.pop_front());
      end
      send_transaction(op, code, $urandom, $urandom, 1'b0, NO_RES, idle_en);
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (FIFO_DEPTH + 4) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
